### rtl/core/vss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_pkg: shared types and constants for the voxel sphere shell rasterizer
// Grid size, radius limit, beat structs and the small offset-square table.
// ----------------------------------------------------------------------------
package vss_pkg;

  // Voxel grid size and radius limit
  localparam int unsigned GRID_X     = 128;
  localparam int unsigned GRID_Y     = 128;
  localparam int unsigned GRID_Z     = 64;
  localparam int unsigned MAX_RADIUS = 3;

  // Mask that picks the dimmed shell colour bits
  localparam logic [7:0] DIM_MASK = 8'h92;

  // One lane per z voxel of a column (2 * max radius + 1)
  localparam int unsigned N_LANES = 7;

  // Offset from the centre along one axis, -3 .. 3
  typedef logic signed [2:0] ofs_t;

  // Input beat: one sphere
  typedef struct packed {
    logic [6:0] centre_x;
    logic [6:0] centre_y;
    logic [5:0] centre_z;
    logic [1:0] sphere_radius;
    logic [7:0] paint_colour;
  } vss_in_t;

  // Output beat: one voxel column
  typedef struct packed {
    logic [6:0] column_x;
    logic [6:0] column_y;
    logic [5:0] z_base;
    logic [6:0] fill_mask;
    logic [6:0] shell_mask;
    logic [7:0] body_colour;
    logic [7:0] shell_colour;
    logic       last_column;
  } vss_out_t;

  // Request to the column evaluator
  typedef struct packed {
    ofs_t       dx;
    ofs_t       dy;
    ofs_t       zlo;
    logic [2:0] span;   // window height - 1
    logic [3:0] rosq;   // r squared
    logic [3:0] risq;   // (r-1) squared
  } vss_col_req_t;

  // Column evaluator result
  typedef struct packed {
    logic [6:0] fill;
    logic [6:0] shell;
  } vss_col_res_t;

  // Square of a small signed offset
  function automatic logic [3:0] sq_ofs(input ofs_t v);
    logic [3:0] s;
    case (v)
      3'sd0:   s = 4'd0;
      3'sd1:   s = 4'd1;
      -3'sd1:  s = 4'd1;
      3'sd2:   s = 4'd4;
      -3'sd2:  s = 4'd4;
      3'sd3:   s = 4'd9;
      -3'sd3:  s = 4'd9;
      default: s = 4'd0;  // -4 never occurs
    endcase
    return s;
  endfunction

endpackage

### rtl/core/vss_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_clip: clips one axis of the sphere bounding box to the grid
// Gives the low and high offsets from the centre and flags an empty window.
// ----------------------------------------------------------------------------
module vss_clip
  import vss_pkg::*;
(
  input  logic [6:0] c_i,      // centre coordinate
  input  logic [1:0] r_i,      // saturated radius
  input  logic [7:0] size_i,   // grid size on this axis
  output ofs_t       lo_o,
  output ofs_t       hi_o,
  output logic       empty_o
);

  logic              clip_hi;
  logic signed [9:0] hi_wide;
  logic signed [9:0] lo_wide;
  logic        [7:0] top_sum;

  // Low edge: stop at coordinate zero
  assign lo_o = (c_i < {5'b0, r_i}) ? (3'(0) - {1'b0, c_i[1:0]})
                                    : (3'(0) - {1'b0, r_i});

  // High edge: stop at size - 1
  assign top_sum = {1'b0, c_i} + {6'b0, r_i};
  assign clip_hi = (top_sum >= size_i);
  assign hi_wide = $signed({2'b0, size_i}) - 10'sd1 - $signed({3'b0, c_i});
  assign lo_wide = {{7{lo_o[2]}}, lo_o};
  assign hi_o    = clip_hi ? hi_wide[2:0] : {1'b0, r_i};

  // Empty only when the high edge falls below the low edge
  assign empty_o = clip_hi && (hi_wide < lo_wide);

endmodule

### rtl/core/vss_shell_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vss_shell_unit: shared column evaluator
// Squared distance per z lane of one column, compared to r^2 and (r-1)^2.
// ----------------------------------------------------------------------------
module vss_shell_unit
  import vss_pkg::*;
(
  input  vss_col_req_t req_i,
  output vss_col_res_t res_o
);

  logic [4:0] dxy_sq;
  ofs_t       dz   [N_LANES];
  logic [4:0] lsq  [N_LANES];
  logic       lane_on [N_LANES];

  // Column part of the distance, shared by all lanes
  assign dxy_sq = {1'b0, sq_ofs(req_i.dx)} + {1'b0, sq_ofs(req_i.dy)};

  // Independent per-voxel compares
  always_comb begin
    res_o = '0;
    for (int k = 0; k < N_LANES; k++) begin
      dz[k]      = req_i.zlo + 3'(k);
      lsq[k]     = dxy_sq + {1'b0, sq_ofs(dz[k])};
      lane_on[k] = (3'(k) <= req_i.span);
      if (lane_on[k] && (lsq[k] <= {1'b0, req_i.rosq})) begin
        res_o.fill[k] = 1'b1;
        if (lsq[k] > {1'b0, req_i.risq}) begin
          res_o.shell[k] = 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/voxel_sphere_shell_shaded_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_sphere_shell_shaded_core: voxel sphere shell rasterizer, top level
// Clips a sphere's box and emits fill/shell masks for each x,y column.
// ----------------------------------------------------------------------------
// The first column beat passes through the ST_SCAN state and then the output register.
// Throughput: one column per cycle through the shared column evaluator while
//   out_ready_i does not stall the output; a new sphere waits for the last column.
// A sphere whose clipped box is empty gives no beat.
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module voxel_sphere_shell_shaded_core
  import vss_pkg::*;
#(
  parameter int unsigned GridX     = GRID_X,
  parameter int unsigned GridY     = GRID_Y,
  parameter int unsigned GridZ     = GRID_Z,
  parameter int unsigned MaxRadius = MAX_RADIUS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vss_out_t out_data_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e       state_q;
  logic [6:0]   cx_q, cy_q;
  logic [5:0]   cz_q;
  logic [7:0]   colour_q;
  ofs_t         dx_q, dy_q, xhi_q, ylo_q, yhi_q, zlo_q;
  logic [2:0]   span_q;
  logic [3:0]   rosq_q, risq_q;
  logic         out_valid_q;
  vss_out_t     out_q;

  logic [1:0]   r_sat;
  ofs_t         xlo_c, xhi_c, ylo_c, yhi_c, zlo_c, zhi_c;
  logic         xe_c, ye_c, ze_c;
  logic         in_beat, load, col_last;
  ofs_t         span_c;
  vss_col_req_t req;
  vss_col_res_t res;

  // Radius saturation
  assign r_sat = (in_data_i.sphere_radius > 2'(MaxRadius)) ? 2'(MaxRadius)
                                                          : in_data_i.sphere_radius;

  // Per-axis clipping of the incoming sphere
  vss_clip u_clip_x (
    .c_i    (in_data_i.centre_x),
    .r_i    (r_sat),
    .size_i (8'(GridX)),
    .lo_o   (xlo_c),
    .hi_o   (xhi_c),
    .empty_o(xe_c)
  );

  vss_clip u_clip_y (
    .c_i    (in_data_i.centre_y),
    .r_i    (r_sat),
    .size_i (8'(GridY)),
    .lo_o   (ylo_c),
    .hi_o   (yhi_c),
    .empty_o(ye_c)
  );

  vss_clip u_clip_z (
    .c_i    ({1'b0, in_data_i.centre_z}),
    .r_i    (r_sat),
    .size_i (8'(GridZ)),
    .lo_o   (zlo_c),
    .hi_o   (zhi_c),
    .empty_o(ze_c)
  );

  assign span_c = zhi_c - zlo_c;

  // Column evaluator fed from the scan counters
  assign req.dx   = dx_q;
  assign req.dy   = dy_q;
  assign req.zlo  = zlo_q;
  assign req.span = span_q;
  assign req.rosq = rosq_q;
  assign req.risq = risq_q;

  vss_shell_unit u_shell (
    .req_i(req),
    .res_o(res)
  );

  // Handshake
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign load        = (state_q == ST_SCAN) && (!out_valid_q || out_ready_i);
  assign col_last    = (dx_q == xhi_q) && (dy_q == yhi_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer, scan counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_beat && !(xe_c || ye_c || ze_c)) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (load) begin
            out_valid_q <= 1'b1;
            if (col_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Sphere parameters and scan position (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cx_q     <= in_data_i.centre_x;
      cy_q     <= in_data_i.centre_y;
      cz_q     <= in_data_i.centre_z;
      colour_q <= in_data_i.paint_colour;
      dx_q     <= xlo_c;
      dy_q     <= ylo_c;
      xhi_q    <= xhi_c;
      ylo_q    <= ylo_c;
      yhi_q    <= yhi_c;
      zlo_q    <= zlo_c;
      span_q   <= span_c;
      rosq_q   <= sq_ofs({1'b0, r_sat});
      risq_q   <= (r_sat == 2'd0) ? 4'd1 : sq_ofs({1'b0, r_sat - 2'd1});
    end else if (load) begin
      if (dy_q == yhi_q) begin
        dy_q <= ylo_q;
        dx_q <= dx_q + 3'sd1;
      end else begin
        dy_q <= dy_q + 3'sd1;
      end
    end
    if (load) begin
      out_q.column_x     <= cx_q + {{4{dx_q[2]}}, dx_q};
      out_q.column_y     <= cy_q + {{4{dy_q[2]}}, dy_q};
      out_q.z_base       <= cz_q + {{3{zlo_q[2]}}, zlo_q};
      out_q.fill_mask    <= res.fill;
      out_q.shell_mask   <= res.shell;
      out_q.body_colour  <= colour_q;
      out_q.shell_colour <= (colour_q & DIM_MASK) >> 1;
      out_q.last_column  <= col_last;
    end
  end

  // Shell voxels are always inside voxels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.shell_mask & ~out_data_o.fill_mask) == 7'd0))
    else $error("shell mask has a voxel outside the fill mask");

  // Inner counter stays within the clipped y window while scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((dy_q >= ylo_q) && (dy_q <= yhi_q)))
    else $error("y scan counter left the clipped window");

  // Loading the final column ends the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && col_last) |=> (state_q == ST_IDLE))
    else $error("scan did not end after the last column");

  // A loaded column is flagged last exactly when the scan ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_data_o.last_column == (state_q == ST_IDLE)))
    else $error("last column flag disagrees with sequencer");

endmodule
